// ===== rtl/pfba_pkg.sv =====
package pfba_pkg;

   // bitmap geometry
   localparam int MAX_FRAMES  = 4096;
   localparam int WORD_BITS   = 32;
   localparam int WORD_COUNT  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W  = $clog2(WORD_COUNT);
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);

   // field widths
   localparam int FRAME_W     = 12;
   localparam int COUNT_W     = 13;
   localparam int FRAME_SPAN  = 4096;
   localparam int LIMIT_CAP   = (MAX_FRAMES < FRAME_SPAN) ? MAX_FRAMES : FRAME_SPAN;

   // register map
   localparam int CSR_ADDR_W  = 2;
   localparam logic [CSR_ADDR_W-1:0] FRAME_COUNT_ADDR = 2'd0;
   localparam logic [COUNT_W-1:0]    FRAME_COUNT_RESET = 13'd4096;

   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_TEST  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOP       = 2'd1,
      ST_NONE_FREE = 2'd2
   } status_type;

   // request beat, last field in the lowest bits
   typedef struct packed {
      logic [FRAME_W-1:0] frame_number;
      logic               is_writable;
      logic               is_kernel;
      logic [FRAME_W-1:0] current_frame;
      logic [1:0]         action;
   } req_type;

   // response beat, last field in the lowest bits
   typedef struct packed {
      logic               in_use;
      logic               user_mode;
      logic               read_write;
      logic               present;
      logic [FRAME_W-1:0] frame;
      status_type         status;
   } rsp_type;

   localparam int REQ_W      = $bits(req_type);
   localparam int RSP_W      = $bits(rsp_type);
   localparam int REQ_DATA_W = ((REQ_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((RSP_W + 7) / 8) * 8;

endpackage

// ===== rtl/page_frame_bitmap_allocator.sv =====
// First-fit page frame allocator over a used-bit bitmap.
// req channel: one beat per request (allocate, free or test of a frame).
// rsp channel: exactly one beat per request, in request order.
// csr port: frame_count at byte address 0, the number of frames managed.
// The bitmap sits in a 128 x 32 synchronous memory with registered reads.
// Request handling, from request beat to response beat:
//   allocate with a frame already assigned, free with no frame,
//   unknown action: straight to the done state
//   free of a frame, test: one memory read, then for a free modify and write back
//   allocate: a scan from word 0 up to the last word read (the word
//   holding the frame, or the last word checked when none is free);
//   the scan reads one bitmap word per cycle, up to 128 words
// One request is in work at a time; the next request beat is taken once
// the current one has its response in the output register, even while
// that response still waits for rsp_tready. A stalled receiver holds the
// response and, after one more request, stops further requests.
// Reset: all frames free at once (per-word valid bits, no clearing pass),
// frame_count back to 4096, no response pending.
module page_frame_bitmap_allocator (
   input  logic                              clock,
   input  logic                              reset,
   // fields from bit 0: action, current_frame, is_kernel, is_writable, frame_number
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pfba_pkg::REQ_DATA_W-1:0]   req_tdata,
   // fields from bit 0: status, frame, present, read_write, user_mode, in_use
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pfba_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pfba_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import pfba_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_RMW  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   rsp_type                res_ff, res_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WORD_IDX_W-1:0]  chk_ff, chk_in;
   logic [COUNT_W-1:0]     frame_count_ff;

   // bitmap memory
   logic [WORD_BITS-1:0]   bitmap_mem [WORD_COUNT];
   logic [WORD_COUNT-1:0]  valid_ff;
   logic [WORD_BITS-1:0]   rd_word_ff;
   logic                   rd_valid_ff;
   logic                   rd_en, wr_en;
   logic [WORD_IDX_W-1:0]  rd_addr, wr_addr;
   logic [WORD_BITS-1:0]   wr_word;
   logic [WORD_BITS-1:0]   word;

   req_type                req_beat;
   logic                   req_take;
   logic [COUNT_W-1:0]     limit;
   logic [WORD_IDX_W:0]    limit_words;
   logic [BIT_IDX_W-1:0]   limit_bits;
   logic [WORD_BITS-1:0]   usable;
   logic [WORD_BITS-1:0]   free_vec;
   logic                   found;
   logic [BIT_IDX_W-1:0]   found_idx;
   logic                   scan_end;
   logic [BIT_IDX_W-1:0]   bit_sel;
   logic                   csr_wr;

   assign req_beat   = req_type'(req_tdata[REQ_W-1:0]);
   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff);

   // an entry never written since reset reads as all free
   assign word = rd_valid_ff ? rd_word_ff : '0;

   // managed limit, capped by the bitmap size
   assign limit       = (frame_count_ff > COUNT_W'(LIMIT_CAP)) ? COUNT_W'(LIMIT_CAP)
                                                               : frame_count_ff;
   assign limit_words = limit[COUNT_W-1:BIT_IDX_W];
   assign limit_bits  = limit[BIT_IDX_W-1:0];

   // frames of the word under check that lie below the limit
   always_comb begin
      if ({1'b0, chk_ff} < limit_words) begin
         usable = '1;
      end else if ({1'b0, chk_ff} == limit_words) begin
         usable = (WORD_BITS'(1) << limit_bits) - WORD_BITS'(1);
      end else begin
         usable = '0;
      end
   end

   assign free_vec = ~word & usable;

   // lowest free bit of the word
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            found     = 1'b1;
            found_idx = BIT_IDX_W'(i);
         end
      end
   end

   // no later word can hold a frame below the limit
   assign scan_end = (chk_ff == WORD_IDX_W'(WORD_COUNT - 1)) ||
                     ({1'b0, chk_ff} >= limit_words);

   assign bit_sel = (req_ff.action == ACT_FREE) ? req_ff.current_frame[BIT_IDX_W-1:0]
                                                : req_ff.frame_number[BIT_IDX_W-1:0];

   // request sequencer
   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      res_in   = res_ff;
      chk_in   = chk_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = chk_ff;
      wr_word  = word;
      rsp_in   = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               req_in = req_beat;
               res_in = '{in_use: 1'b0, user_mode: 1'b0, read_write: 1'b0,
                          present: 1'b0, frame: '0, status: ST_NOP};
               case (req_beat.action)
                  ACT_ALLOC: begin
                     if (req_beat.current_frame != '0) begin
                        res_in.frame = req_beat.current_frame;
                        state_in     = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        chk_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  ACT_FREE: begin
                     if (req_beat.current_frame != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_beat.current_frame[FRAME_W-1:BIT_IDX_W];
                        state_in = S_RMW;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  ACT_TEST: begin
                     rd_en    = 1'b1;
                     rd_addr  = req_beat.frame_number[FRAME_W-1:BIT_IDX_W];
                     state_in = S_RMW;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // read the next word while this one is checked
            rd_en   = 1'b1;
            rd_addr = chk_ff + WORD_IDX_W'(1);
            if (found) begin
               wr_en   = 1'b1;
               wr_addr = chk_ff;
               wr_word = word | (WORD_BITS'(1) << found_idx);
               res_in.status     = ST_DONE;
               res_in.frame      = {chk_ff, found_idx};
               res_in.present    = 1'b1;
               res_in.read_write = req_ff.is_writable;
               res_in.user_mode  = !req_ff.is_kernel;
               state_in = S_DONE;
            end else if (scan_end) begin
               res_in.status = ST_NONE_FREE;
               state_in = S_DONE;
            end else begin
               chk_in = chk_ff + WORD_IDX_W'(1);
            end
         end
         S_RMW: begin
            res_in.status = ST_DONE;
            if (req_ff.action == ACT_FREE) begin
               wr_en   = 1'b1;
               wr_addr = req_ff.current_frame[FRAME_W-1:BIT_IDX_W];
               wr_word = word & ~(WORD_BITS'(1) << bit_sel);
            end else begin
               res_in.in_use = word[bit_sel];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      chk_ff <= chk_in;
   end

   // bitmap storage and read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem[wr_addr] <= wr_word;
      end
      if (rd_en) begin
         rd_word_ff <= bitmap_mem[rd_addr];
      end
   end

   // per-word written marks
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // configuration port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == FRAME_COUNT_ADDR) ? 32'(frame_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FRAME_COUNT_RESET;
      end else if (csr_wr && (csr_paddr == FRAME_COUNT_ADDR)) begin
         frame_count_ff <= csr_pwdata[COUNT_W-1:0];
      end
   end

   // bitmap writes only come from the scan hit or the free write-back
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_SCAN || state_ff == S_RMW))
      else $error("bitmap written outside scan or write-back");

   // a taken request is never followed by another in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_tready)
      else $error("request taken while previous still in work");

   // a new response only comes out of the done state
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_tready)) |-> (state_ff == S_DONE))
      else $error("response loaded outside done state");

   // the scan never runs past the managed limit
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> ({1'b0, chk_ff} <= limit_words))
      else $error("scan beyond frame limit");

endmodule
